// ===== src/ffck_pkg.sv =====
// Shared types and constants for the four-function calculator keypad block.
// Used by the calculator top level, its multiply/divide unit and the port checker.
package ffck_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int SHOWN_WIDTH     = 32;
    localparam int RADIX_DEC       = 10;
    localparam int RADIX_HEX       = 16;

    // key codes
    localparam logic [3:0] KEY_DIGIT  = 4'd0;
    localparam logic [3:0] KEY_PLUS   = 4'd1;
    localparam logic [3:0] KEY_MINUS  = 4'd2;
    localparam logic [3:0] KEY_TIMES  = 4'd3;
    localparam logic [3:0] KEY_DIVIDE = 4'd4;
    localparam logic [3:0] KEY_EQUALS = 4'd5;
    localparam logic [3:0] KEY_CLEAR  = 4'd6;
    localparam logic [3:0] KEY_HEX    = 4'd7;
    localparam logic [3:0] KEY_DEC    = 4'd8;

    typedef enum logic [1:0] {
        ARITH_ADD = 2'd0,
        ARITH_SUB = 2'd1,
        ARITH_MUL = 2'd2,
        ARITH_DIV = 2'd3
    } arith_op_t;

    typedef enum logic [1:0] {
        KC_RESET = 2'd0,
        KC_DIGIT = 2'd1,
        KC_OPER  = 2'd2,
        KC_EQUAL = 2'd3
    } key_class_t;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] digit;
    } key_item_t;

    typedef struct packed {
        logic signed [SHOWN_WIDTH-1:0] shown_value;
        logic                          error_flag;
        logic                          hex_shown;
    } disp_item_t;

    // request to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } alu_req_t;

endpackage

// ===== src/ffck_alu.sv =====
// Iterative multiply / truncating divide unit, one operand bit per cycle.
// Depends on ffck_pkg.
module ffck_alu
    import ffck_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  alu_req_t               req,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] result
);

    localparam int W    = VALUE_WIDTH;
    localparam int CntW = $clog2(W);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            div_reg, div_next;
    logic            neg_reg, neg_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]    x_reg, x_next;   // multiplicand, or dividend shifting into quotient
    logic [W-1:0]    y_reg, y_next;   // multiplier, or divisor magnitude
    logic [W-1:0]    r_reg, r_next;   // product, or partial remainder

    logic [W-1:0]    rem_sh;
    logic [W:0]      diff;
    logic            sa, sb;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        r_next    = r_reg;

        sa     = a[W-1];
        sb     = b[W-1];
        // remainder stays below the divisor, so its top bit is zero here
        rem_sh = {r_reg[W-2:0], x_reg[W-1]};
        diff   = {1'b0, rem_sh} - {1'b0, y_reg};

        if (req.start)
        begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            cnt_next  = CntW'(W - 1);
            r_next    = '0;
            if (req.is_div)
            begin
                x_next   = sa ? (~a + 1'b1) : a;
                y_next   = sb ? (~b + 1'b1) : b;
                neg_next = sa ^ sb;
            end
            else
            begin
                x_next   = a;
                y_next   = b;
                neg_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (!diff[W])
                begin
                    r_next = diff[W-1:0];
                    x_next = {x_reg[W-2:0], 1'b1};
                end
                else
                begin
                    r_next = rem_sh;
                    x_next = {x_reg[W-2:0], 1'b0};
                end
            end
            else
            begin
                if (y_reg[0])
                begin
                    r_next = r_reg + x_reg;
                end
                x_next = {x_reg[W-2:0], 1'b0};
                y_next = {1'b0, y_reg[W-1:1]};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        r_reg   <= r_next;
    end

    assign done   = done_reg;
    assign result = div_reg ? (neg_reg ? (~x_reg + 1'b1) : x_reg) : r_reg;

endmodule

// ===== src/four_function_calculator_keypad.sv =====
// Four-function integer calculator driven by one key event per item; every key
// returns one display item. A key that computes nothing, or that completes a pending
// add or subtract, is shown in the cycle after it is taken. An operator or equals key
// that completes a pending multiply, or a divide by a nonzero entry, hands the work to
// the bit-per-cycle shift-add / restoring-divide unit, and its display item is loaded
// when that unit signals done; no key is taken meanwhile. A new key is taken once the
// display item before it is delivered or is being delivered in the same cycle.
// Depends on ffck_pkg and ffck_alu.
module four_function_calculator_keypad
    import ffck_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       key_valid,
    output logic       key_stall,
    input  key_item_t  key,
    output logic       disp_valid,
    input  logic       disp_stall,
    output disp_item_t disp
);

    localparam int W = VALUE_WIDTH;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    state_t     state_reg, state_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] entry_reg, entry_next;
    arith_op_t  pend_reg, pend_next;
    key_class_t kc_reg, kc_next;
    logic       hex_reg, hex_next;
    logic       err_reg, err_next;
    logic       disp_valid_reg, disp_valid_next;
    disp_item_t disp_reg, disp_next;

    logic         accept;
    logic         load_out;
    logic         is_oper;
    arith_op_t    key_arith;
    logic [W-1:0] digit_ext;
    logic [W-1:0] entry_grown;
    alu_req_t     alu_req;
    logic         alu_done;
    logic [W-1:0] alu_result;

    ffck_alu #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (acc_reg),
        .b      (entry_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    assign key_stall = (state_reg != ST_IDLE) || (disp_valid_reg && disp_stall);
    assign accept    = key_valid && !key_stall;

    assign digit_ext   = W'(key.digit);
    assign entry_grown = hex_reg ? ({entry_reg[W-5:0], 4'b0000} | digit_ext)
                                 : ({entry_reg[W-4:0], 3'b000} + {entry_reg[W-2:0], 1'b0}
                                    + digit_ext);

    always_comb
    begin
        case (key.op)
            KEY_PLUS:   key_arith = ARITH_ADD;
            KEY_MINUS:  key_arith = ARITH_SUB;
            KEY_TIMES:  key_arith = ARITH_MUL;
            default:    key_arith = ARITH_DIV;
        endcase
        is_oper = (key.op == KEY_PLUS) || (key.op == KEY_MINUS)
               || (key.op == KEY_TIMES) || (key.op == KEY_DIVIDE);
    end

    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        entry_next      = entry_reg;
        pend_next       = pend_reg;
        kc_next         = kc_reg;
        hex_next        = hex_reg;
        err_next        = err_reg;
        load_out        = 1'b0;
        alu_req.start   = 1'b0;
        alu_req.is_div  = (pend_reg == ARITH_DIV);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    case (key.op)
                        KEY_DIGIT:
                        begin
                            if (!err_reg && (hex_reg || (key.digit < 4'(RADIX_DEC))))
                            begin
                                if (kc_reg == KC_EQUAL)
                                begin
                                    acc_next  = '0;
                                    pend_next = ARITH_ADD;
                                end
                                entry_next = (kc_reg == KC_DIGIT) ? entry_grown : digit_ext;
                                kc_next    = KC_DIGIT;
                            end
                        end
                        KEY_PLUS, KEY_MINUS, KEY_TIMES, KEY_DIVIDE, KEY_EQUALS:
                        begin
                            if (!err_reg)
                            begin
                                if (kc_reg == KC_DIGIT)
                                begin
                                    case (pend_reg)
                                        ARITH_ADD:
                                        begin
                                            acc_next   = acc_reg + entry_reg;
                                            entry_next = acc_reg + entry_reg;
                                        end
                                        ARITH_SUB:
                                        begin
                                            acc_next   = acc_reg - entry_reg;
                                            entry_next = acc_reg - entry_reg;
                                        end
                                        ARITH_MUL:
                                        begin
                                            alu_req.start = 1'b1;
                                        end
                                        default:
                                        begin
                                            if (entry_reg == '0)
                                            begin
                                                err_next = 1'b1;
                                            end
                                            else
                                            begin
                                                alu_req.start = 1'b1;
                                            end
                                        end
                                    endcase
                                end
                                if (is_oper)
                                begin
                                    pend_next = key_arith;
                                    kc_next   = KC_OPER;
                                end
                                else
                                begin
                                    kc_next = KC_EQUAL;
                                end
                            end
                        end
                        KEY_CLEAR, KEY_HEX, KEY_DEC:
                        begin
                            // same-mode key is a no-op, error included
                            if ((key.op == KEY_CLEAR) || ((key.op == KEY_HEX) != hex_reg))
                            begin
                                err_next   = 1'b0;
                                acc_next   = '0;
                                entry_next = '0;
                                pend_next  = ARITH_ADD;
                                kc_next    = KC_RESET;
                                if (key.op != KEY_CLEAR)
                                begin
                                    hex_next = (key.op == KEY_HEX);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (alu_req.start)
                    begin
                        load_out   = 1'b0;
                        state_next = ST_BUSY;
                    end
                end
            end
            ST_BUSY:
            begin
                if (alu_done)
                begin
                    acc_next   = alu_result;
                    entry_next = alu_result;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        disp_valid_next = disp_valid_reg && disp_stall;
        disp_next       = disp_reg;
        if (load_out)
        begin
            disp_valid_next       = 1'b1;
            disp_next.shown_value = err_next ? '0 : SHOWN_WIDTH'($signed(entry_next));
            disp_next.error_flag  = err_next;
            disp_next.hex_shown   = hex_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            acc_reg        <= '0;
            entry_reg      <= '0;
            pend_reg       <= ARITH_ADD;
            kc_reg         <= KC_RESET;
            hex_reg        <= 1'b0;
            err_reg        <= 1'b0;
            disp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            acc_reg        <= acc_next;
            entry_reg      <= entry_next;
            pend_reg       <= pend_next;
            kc_reg         <= kc_next;
            hex_reg        <= hex_next;
            err_reg        <= err_next;
            disp_valid_reg <= disp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        disp_reg <= disp_next;
    end

    assign disp_valid = disp_valid_reg;
    assign disp       = disp_reg;

endmodule

// ===== src/ffck_chk.sv =====
// Port-level checker for the calculator keypad block, bound to the top level.
// Depends on ffck_pkg.
module ffck_chk
    import ffck_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       key_valid,
    input logic       key_stall,
    input key_item_t  key,
    input logic       disp_valid,
    input logic       disp_stall,
    input disp_item_t disp
);

    // a waiting display item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && disp_stall |=> disp_valid && $stable(disp))
        else $error("display item changed while stalled");

    // no key is taken while a display item is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && disp_stall |-> key_stall)
        else $error("key taken while display blocked");

    assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && disp.error_flag |-> disp.shown_value == '0)
        else $error("nonzero value shown with error");

    assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_stall && key.op == KEY_CLEAR
        |=> disp_valid && !disp.error_flag && disp.shown_value == '0)
        else $error("clear did not show zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_stall && key.op == KEY_HEX |=> disp_valid && disp.hex_shown)
        else $error("hex key did not enter hex mode");

endmodule

bind four_function_calculator_keypad ffck_chk u_ffck_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_valid  (key_valid),
    .key_stall  (key_stall),
    .key        (key),
    .disp_valid (disp_valid),
    .disp_stall (disp_stall),
    .disp       (disp)
);
